// ----- rtl/swm_pkg.sv -----
// swm_pkg: shared widths, deque entry and interface types for sliding_window_max.
// No dependencies; used by every rtl file of the block.
`timescale 1ns / 1ps

package swm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int DEPTH    = 64;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = ADDR_W + 1;       // holds 0..DEPTH
   localparam int POS_W    = ADDR_W + 1;       // positions wrap modulo 2*DEPTH
   localparam int WIN_W    = 7;                // window_size register width
   localparam int CMP_W    = SAMPLE_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FRONT = 4'b0010,
      ST_BACK  = 4'b0100,
      ST_PUSH  = 4'b1000
   } state_type;

   typedef struct packed {
      logic [POS_W-1:0]           tag;
      logic signed [SAMPLE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      entry_type         wdata;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] value;
   } result_type;

endpackage

// ----- rtl/swm_ram.sv -----
// swm_ram: deque storage, one write and one registered read per cycle.
// Depends on swm_pkg for the entry and request types.
`timescale 1ns / 1ps

module swm_ram (
   input  logic                 clock,
   input  swm_pkg::ram_req_type ram_req,
   output swm_pkg::entry_type   ram_rdata
);

   swm_pkg::entry_type deque_mem [swm_pkg::DEPTH];
   swm_pkg::entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         deque_mem[ram_req.waddr] <= ram_req.wdata;
      end
      rdata_ff <= deque_mem[ram_req.raddr];
   end

   assign ram_rdata = rdata_ff;

endmodule

// ----- rtl/swm_seq.sv -----
// swm_seq: sequencer for the monotonic deque, with the one shared comparator.
// Depends on swm_pkg; drives swm_ram through a request struct.
`timescale 1ns / 1ps

module swm_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                               req_first,
   input  logic [swm_pkg::WIN_W-1:0]          win,
   input  logic                               rsp_free,
   output swm_pkg::ram_req_type               ram_req,
   input  swm_pkg::entry_type                 ram_rdata,
   output swm_pkg::result_type                res
);

   swm_pkg::state_type state_ff, state_in;
   logic [swm_pkg::ADDR_W-1:0] head_ff, head_in;
   logic [swm_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [swm_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [swm_pkg::CNT_W-1:0]  fill_ff, fill_in;
   logic signed [swm_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [swm_pkg::SAMPLE_W-1:0] front_ff, front_in;

   logic [swm_pkg::CNT_W-1:0]  w_eff;
   logic [swm_pkg::POS_W-1:0]  age;
   logic [swm_pkg::CNT_W-1:0]  fill_next;
   logic signed [swm_pkg::CMP_W-1:0] cmp_a, cmp_b;
   logic                       cmp_lt;

   // zero acts as one, anything above the deque depth saturates
   always_comb begin
      if (win == '0) begin
         w_eff = swm_pkg::CNT_W'(1);
      end else if (win > swm_pkg::WIN_W'(swm_pkg::DEPTH)) begin
         w_eff = swm_pkg::CNT_W'(swm_pkg::DEPTH);
      end else begin
         w_eff = swm_pkg::CNT_W'(win);
      end
   end

   assign age = pos_ff - ram_rdata.tag;

   // shared comparator: age against window when checking the front,
   // stored value against the new sample when checking the back
   always_comb begin
      if (state_ff == swm_pkg::ST_FRONT) begin
         cmp_a = $signed({{(swm_pkg::CMP_W-swm_pkg::POS_W){1'b0}}, age});
         cmp_b = $signed({{(swm_pkg::CMP_W-swm_pkg::CNT_W){1'b0}}, w_eff});
      end else begin
         cmp_a = $signed({ram_rdata.value[swm_pkg::SAMPLE_W-1], ram_rdata.value});
         cmp_b = $signed({sample_ff[swm_pkg::SAMPLE_W-1], sample_ff});
      end
   end

   assign cmp_lt = cmp_a < cmp_b;

   assign fill_next = (fill_ff == swm_pkg::CNT_W'(swm_pkg::DEPTH)) ? fill_ff
                                                                    : fill_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      fill_in       = fill_ff;
      sample_in     = sample_ff;
      front_in      = front_ff;
      ram_req.we    = 1'b0;
      ram_req.waddr = head_ff + count_ff[swm_pkg::ADDR_W-1:0];
      ram_req.wdata.tag   = pos_ff;
      ram_req.wdata.value = sample_ff;
      ram_req.raddr = head_ff;
      res.valid     = 1'b0;
      res.value     = (count_ff == '0) ? sample_ff : front_ff;

      unique case (state_ff)
         swm_pkg::ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               if (req_first) begin
                  head_in  = '0;
                  count_in = '0;
                  pos_in   = '0;
                  fill_in  = '0;
                  state_in = swm_pkg::ST_PUSH;
               end else if (count_ff != '0) begin
                  state_in = swm_pkg::ST_FRONT;  // front tag read issued now
               end else begin
                  state_in = swm_pkg::ST_PUSH;
               end
            end
         end
         swm_pkg::ST_FRONT: begin
            if (!cmp_lt) begin
               // front entry has left the window
               head_in  = head_ff + 1'b1;
               count_in = count_ff - 1'b1;
               ram_req.raddr = head_ff + 1'b1;
               if (count_ff == swm_pkg::CNT_W'(1)) begin
                  state_in = swm_pkg::ST_PUSH;
               end
            end else begin
               front_in = ram_rdata.value;
               ram_req.raddr = head_ff + swm_pkg::ADDR_W'(count_ff - 1'b1);
               state_in = swm_pkg::ST_BACK;
            end
         end
         swm_pkg::ST_BACK: begin
            if (cmp_lt) begin
               count_in = count_ff - 1'b1;
               ram_req.raddr = head_ff + swm_pkg::ADDR_W'(count_ff - 2'd2);
               if (count_ff == swm_pkg::CNT_W'(1)) begin
                  state_in = swm_pkg::ST_PUSH;
               end
            end else begin
               state_in = swm_pkg::ST_PUSH;
            end
         end
         swm_pkg::ST_PUSH: begin
            if (rsp_free) begin
               if (count_ff != swm_pkg::CNT_W'(swm_pkg::DEPTH)) begin
                  ram_req.we = 1'b1;
                  count_in   = count_ff + 1'b1;
               end
               fill_in   = fill_next;
               pos_in    = pos_ff + 1'b1;
               res.valid = (fill_next >= w_eff);
               state_in  = swm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swm_pkg::ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         fill_ff  <= fill_in;
      end
      sample_ff <= sample_in;
      front_ff  <= front_in;
   end

   assign req_ready = (state_ff == swm_pkg::ST_IDLE);

endmodule

// ----- rtl/sliding_window_max.sv -----
// Sliding window maximum over a stream of signed 32-bit samples, kept as a
// monotonic deque of up to 64 candidates in a single-port-read RAM. A sample
// goes straight to the push when req_first is set or the deque is empty on
// arrival. Otherwise the sequencer first drops the entries that have left the
// window from the front; if any remain, it keeps the front value and pops the
// entries below the new sample from the back, then pushes. The push also
// waits while an earlier result is still untaken. The sequencer makes one
// comparison a cycle through one shared comparator and one RAM read. Each
// sample is pushed once and removed at most once. A result is given only once
// window_size samples have arrived since reset or the last transfer with
// req_first set.
// Depends on swm_pkg, swm_ram and swm_seq.
`timescale 1ns / 1ps

module sliding_window_max (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_first,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [swm_pkg::SAMPLE_W-1:0] rsp_max_value,
   input  logic                                csr_we,
   input  logic [swm_pkg::WIN_W-1:0]           csr_wdata
);

   logic [swm_pkg::WIN_W-1:0] win_ff;
   logic                      rsp_valid_ff;
   logic signed [swm_pkg::SAMPLE_W-1:0] rsp_value_ff;
   logic                      rsp_free;
   swm_pkg::ram_req_type      ram_req;
   swm_pkg::entry_type        ram_rdata;
   swm_pkg::result_type       res;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   swm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_first  (req_first),
      .win        (win_ff),
      .rsp_free   (rsp_free),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata),
      .res        (res)
   );

   swm_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= swm_pkg::WIN_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            win_ff <= csr_wdata;
         end
         if (res.valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (res.valid) begin
         rsp_value_ff <= res.value;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_value_ff;

endmodule

// ----- rtl/swm_checker.sv -----
// swm_checker: port-level checks on sliding_window_max, attached by bind.
// Depends on swm_pkg for widths.
`timescale 1ns / 1ps

module swm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [swm_pkg::SAMPLE_W-1:0] rsp_max_value
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_max_value))
      else $error("result changed while stalled");

   // one sample at a time: busy straight after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while previous sample in progress");

   // a new result only comes at the end of a sample's work
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without a sample in progress");

   // reset leaves the block ready and with no result
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind sliding_window_max swm_checker u_swm_checker (.*);
